// File: src/sme_pkg.sv
// Shared types, codes and sizing constants for the slot mailbox engine.
package sme_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int MSG_MAX   = 64;

  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MEM_DEPTH = NUM_SLOTS * MSG_MAX;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int CNT_W     = 7;
  localparam int FROM_W    = 9;

  localparam logic [FROM_W-1:0] NO_SENDER = '1;

  typedef enum logic [1:0] {
    MODE_SEND  = 2'd0,
    MODE_RECV  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_BAD_ARG  = 3'd1,
    STS_NOT_RUN  = 3'd2,
    STS_OCCUPIED = 3'd3,
    STS_EMPTY    = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic rd_issue;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rx_go;
    logic rd_last;
  } sts_t;

endpackage

// File: src/sme_ctrl.sv
// Controller state machine: accepts beats and sequences message read-out.
module sme_ctrl
  import sme_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;

  // advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // choose next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && sts.rx_go) state_nxt = ST_READ;
      end
      ST_READ: begin
        if (sts.rd_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // drive commands
  always_comb begin
    busy         = (state_r == ST_READ);
    cmd.accept   = start && !busy;
    cmd.rd_issue = (state_r == ST_READ);
  end

endmodule

// File: src/sme_dp.sv
// Datapath: message store, slot tables, run tracking, counters and result registers.
module sme_dp
  import sme_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [1:0]               in_mode,
  input  logic [7:0]               in_slot,
  input  logic [7:0]               in_sender,
  input  logic                     in_dest_running,
  input  logic [7:0]               in_length,
  input  logic [7:0]               in_data_byte,
  output logic                     out_valid,
  output logic [2:0]               out_status,
  output logic [7:0]               out_out_byte,
  output logic                     out_byte_valid,
  output logic                     out_last_result,
  output logic [CNT_W-1:0]         out_byte_count,
  output logic signed [FROM_W-1:0] out_from_id,
  output logic [31:0]              out_sent_count,
  output logic [31:0]              out_delivered_count,
  output logic [31:0]              out_refused_count
);

  // storage
  logic [7:0]        mem [MEM_DEPTH];
  logic [CNT_W-1:0]  slot_len_r  [NUM_SLOTS];
  logic [FROM_W-1:0] slot_from_r [NUM_SLOTS];

  // run state
  logic       run_active_r, run_active_nxt;
  logic [7:0] run_pos_r, run_pos_nxt;
  status_t    run_verdict_r, run_verdict_nxt;
  logic [7:0] run_slot_r, run_slot_nxt;
  logic [7:0] run_sender_r, run_sender_nxt;
  logic [7:0] run_len_r, run_len_nxt;

  // counters
  logic [31:0] sent_r, sent_nxt;
  logic [31:0] dlv_r, dlv_nxt;
  logic [31:0] ref_r, ref_nxt;

  // read-out state
  logic [ADDR_W-1:0] rx_base_r, rx_base_nxt;
  logic [CNT_W-1:0]  rx_take_r, rx_take_nxt;
  logic [FROM_W-1:0] rx_from_r, rx_from_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;

  // result registers
  logic              ov_r;
  status_t           ost_r;
  logic              obv_r;
  logic              olast_r;
  logic [CNT_W-1:0]  ocnt_r;
  logic [FROM_W-1:0] ofrom_r;
  logic [7:0]        mem_q_r;

  // item decode
  mode_t             mode;
  logic              first;
  logic              in_range;
  logic [SLOT_W-1:0] in_idx;
  logic [SLOT_W-1:0] run_idx;
  status_t           new_verdict;
  status_t           verdict;
  logic [7:0]        v_slot;
  logic [7:0]        v_len;
  logic [7:0]        pos;
  logic [7:0]        items;
  logic              done;
  logic [CNT_W-1:0]  cur_len;
  logic [CNT_W-1:0]  take;

  // status to the controller
  logic              rx_go;
  logic              rd_last;

  // memory and table controls
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              tbl_we;
  logic [SLOT_W-1:0] tbl_idx;
  logic [CNT_W-1:0]  tbl_len;
  logic [FROM_W-1:0] tbl_from;

  // next result
  logic              res_vld;
  status_t           res_status;
  logic              res_bv;
  logic              res_last;
  logic [CNT_W-1:0]  res_cnt;
  logic [FROM_W-1:0] res_from;

  assign mode     = mode_t'(in_mode);
  assign first    = !run_active_r;
  assign in_range = ({1'b0, in_slot} < 9'(NUM_SLOTS));
  assign in_idx   = in_slot[SLOT_W-1:0];
  assign v_slot   = first ? in_slot : run_slot_r;
  assign run_idx  = v_slot[SLOT_W-1:0];
  assign v_len    = first ? in_length : run_len_r;
  assign pos      = first ? 8'd0 : run_pos_r;
  assign items    = (v_len == 8'd0) ? 8'd1 : v_len;
  assign done     = ((pos + 8'd1) == items);
  assign cur_len  = slot_len_r[in_idx];
  assign take     = ({1'b0, cur_len} < in_length) ? cur_len : in_length[CNT_W-1:0];
  assign rd_last  = ((rd_idx_r + 7'd1) == rx_take_r);
  assign sts      = '{rx_go: rx_go, rd_last: rd_last};

  // check the first beat of a send run, in priority order
  always_comb begin
    priority if (!in_range || in_length == 8'd0 || {1'b0, in_length} > 9'(MSG_MAX)) begin
      new_verdict = STS_BAD_ARG;
    end else if (!in_dest_running) begin
      new_verdict = STS_NOT_RUN;
    end else if (cur_len != '0) begin
      new_verdict = STS_OCCUPIED;
    end else begin
      new_verdict = STS_OK;
    end
  end

  assign verdict = first ? new_verdict : run_verdict_r;

  // work out every update for this cycle
  always_comb begin
    run_active_nxt  = run_active_r;
    run_pos_nxt     = run_pos_r;
    run_verdict_nxt = run_verdict_r;
    run_slot_nxt    = run_slot_r;
    run_sender_nxt  = run_sender_r;
    run_len_nxt     = run_len_r;
    sent_nxt        = sent_r;
    dlv_nxt         = dlv_r;
    ref_nxt         = ref_r;
    rx_base_nxt     = rx_base_r;
    rx_take_nxt     = rx_take_r;
    rx_from_nxt     = rx_from_r;
    rd_idx_nxt      = rd_idx_r;
    mem_we          = 1'b0;
    mem_waddr       = ADDR_W'(v_slot) * ADDR_W'(MSG_MAX) + ADDR_W'(pos);
    mem_re          = 1'b0;
    mem_raddr       = rx_base_r + ADDR_W'(rd_idx_r);
    tbl_we          = 1'b0;
    tbl_idx         = in_idx;
    tbl_len         = '0;
    tbl_from        = NO_SENDER;
    res_vld         = 1'b0;
    res_status      = STS_OK;
    res_bv          = 1'b0;
    res_last        = 1'b1;
    res_cnt         = '0;
    res_from        = NO_SENDER;
    rx_go           = 1'b0;

    if (cmd.accept) begin
      unique case (mode)
        MODE_SEND: begin
          if (first) begin
            run_slot_nxt    = in_slot;
            run_sender_nxt  = in_sender;
            run_len_nxt     = in_length;
            run_verdict_nxt = new_verdict;
            if (new_verdict != STS_OK) ref_nxt = ref_r + 32'd1;
          end
          // store the byte while it still fits
          if (verdict == STS_OK && {1'b0, pos} < 9'(MSG_MAX)) mem_we = 1'b1;
          run_pos_nxt    = pos + 8'd1;
          run_active_nxt = !done;
          if (done) begin
            res_vld = 1'b1;
            if (verdict == STS_OK) begin
              tbl_we   = 1'b1;
              tbl_idx  = run_idx;
              tbl_len  = v_len[CNT_W-1:0];
              tbl_from = {1'b0, first ? in_sender : run_sender_r};
              sent_nxt = sent_r + 32'd1;
              res_cnt  = v_len[CNT_W-1:0];
            end else begin
              res_status = verdict;
            end
          end
        end
        MODE_RECV: begin
          run_active_nxt = 1'b0;
          priority if (!in_range) begin
            res_vld    = 1'b1;
            res_status = STS_BAD_ARG;
          end else if (cur_len == '0) begin
            res_vld    = 1'b1;
            res_status = STS_EMPTY;
          end else begin
            tbl_we  = 1'b1;
            dlv_nxt = dlv_r + 32'd1;
            if (take == '0) begin
              res_vld  = 1'b1;
              res_from = slot_from_r[in_idx];
            end else begin
              rx_go       = 1'b1;
              rx_base_nxt = ADDR_W'(in_slot) * ADDR_W'(MSG_MAX);
              rx_take_nxt = take;
              rx_from_nxt = slot_from_r[in_idx];
              rd_idx_nxt  = '0;
            end
          end
        end
        MODE_CLEAR: begin
          run_active_nxt = 1'b0;
          tbl_we         = in_range;
        end
        MODE_NONE: begin
        end
        default: begin
        end
      endcase
    end

    // read out one byte per cycle
    if (cmd.rd_issue) begin
      mem_re     = 1'b1;
      rd_idx_nxt = rd_idx_r + 7'd1;
      res_vld    = 1'b1;
      res_bv     = 1'b1;
      res_last   = rd_last;
      res_cnt    = rx_take_r;
      res_from   = rx_from_r;
    end
  end

  // message store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= in_data_byte;
    if (mem_re) mem_q_r <= mem[mem_raddr];
  end

  // slot tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_len_r[i]  <= '0;
        slot_from_r[i] <= NO_SENDER;
      end
    end else if (tbl_we) begin
      slot_len_r[tbl_idx]  <= tbl_len;
      slot_from_r[tbl_idx] <= tbl_from;
    end
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r  <= 1'b0;
      run_pos_r     <= '0;
      run_verdict_r <= STS_OK;
      run_slot_r    <= '0;
      run_sender_r  <= '0;
      run_len_r     <= '0;
      sent_r        <= '0;
      dlv_r         <= '0;
      ref_r         <= '0;
      rd_idx_r      <= '0;
      ov_r          <= 1'b0;
    end else begin
      run_active_r  <= run_active_nxt;
      run_pos_r     <= run_pos_nxt;
      run_verdict_r <= run_verdict_nxt;
      run_slot_r    <= run_slot_nxt;
      run_sender_r  <= run_sender_nxt;
      run_len_r     <= run_len_nxt;
      sent_r        <= sent_nxt;
      dlv_r         <= dlv_nxt;
      ref_r         <= ref_nxt;
      rd_idx_r      <= rd_idx_nxt;
      ov_r          <= res_vld;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rx_base_r <= rx_base_nxt;
    rx_take_r <= rx_take_nxt;
    rx_from_r <= rx_from_nxt;
    ost_r     <= res_status;
    obv_r     <= res_bv;
    olast_r   <= res_last;
    ocnt_r    <= res_cnt;
    ofrom_r   <= res_from;
  end

  // drive result ports
  assign out_valid           = ov_r;
  assign out_status          = ost_r;
  assign out_out_byte        = obv_r ? mem_q_r : 8'd0;
  assign out_byte_valid      = obv_r;
  assign out_last_result     = olast_r;
  assign out_byte_count      = ocnt_r;
  assign out_from_id         = $signed(ofrom_r);
  assign out_sent_count      = sent_r;
  assign out_delivered_count = dlv_r;
  assign out_refused_count   = ref_r;

endmodule

// File: src/slot_mailbox_engine_unit.sv
// Top level of the slot mailbox engine: controller plus datapath.
// Send beats are taken one per cycle while busy is low; a run's status result
// shows in the cycle after its final beat. A receive holds busy while the slot
// memory is read one byte per cycle; bytes appear one per cycle, registered at
// the memory output. Other results show in the cycle after their beat.
// Synchronous active-low reset empties all slots and zeroes counters.
// Results are single-cycle strobes; the receiver cannot stall.
module slot_mailbox_engine_unit
  import sme_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_mode,
  input  logic [7:0]               in_slot,
  input  logic [7:0]               in_sender,
  input  logic                     in_dest_running,
  input  logic [7:0]               in_length,
  input  logic [7:0]               in_data_byte,
  output logic                     out_valid,
  output logic [2:0]               out_status,
  output logic [7:0]               out_out_byte,
  output logic                     out_byte_valid,
  output logic                     out_last_result,
  output logic [CNT_W-1:0]         out_byte_count,
  output logic signed [FROM_W-1:0] out_from_id,
  output logic [31:0]              out_sent_count,
  output logic [31:0]              out_delivered_count,
  output logic [31:0]              out_refused_count
);

  cmd_t cmd;
  sts_t sts;

  sme_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  sme_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_mode             (in_mode),
    .in_slot             (in_slot),
    .in_sender           (in_sender),
    .in_dest_running     (in_dest_running),
    .in_length           (in_length),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_out_byte        (out_out_byte),
    .out_byte_valid      (out_byte_valid),
    .out_last_result     (out_last_result),
    .out_byte_count      (out_byte_count),
    .out_from_id         (out_from_id),
    .out_sent_count      (out_sent_count),
    .out_delivered_count (out_delivered_count),
    .out_refused_count   (out_refused_count)
  );

endmodule

// File: src/sme_checker.sv
// Port-level checks on the slot mailbox engine, bound to its top level.
module sme_checker
  import sme_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     busy,
  input logic                     out_valid,
  input logic [2:0]               out_status,
  input logic [7:0]               out_out_byte,
  input logic                     out_byte_valid,
  input logic                     out_last_result,
  input logic [CNT_W-1:0]         out_byte_count,
  input logic signed [FROM_W-1:0] out_from_id,
  input logic [31:0]              out_sent_count,
  input logic [31:0]              out_delivered_count,
  input logic [31:0]              out_refused_count
);

  // a result without a byte carries a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_out_byte == 8'd0)
    else $error("result without a byte carries a nonzero byte");

  // a byte burst continues without gaps until its last beat
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |=> out_valid && out_byte_valid)
    else $error("byte burst broken before its last beat");

  // byte beats are good status with a nonzero count
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_status == STS_OK && out_byte_count != '0)
    else $error("byte beat with bad status or zero count");

  // refusals carry no count and no sender
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |-> out_byte_count == '0 && out_from_id == -9'sd1)
    else $error("failed result carries a count or a sender");

  // counters move only on an accepted beat, never while busy
  a_counters: assert property (@(posedge clk) disable iff (!rst_n)
    $past(busy) |-> $stable(out_sent_count) && $stable(out_delivered_count)
                    && $stable(out_refused_count))
    else $error("counter changed while busy");

endmodule

bind slot_mailbox_engine_unit sme_checker u_sme_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_status          (out_status),
  .out_out_byte        (out_out_byte),
  .out_byte_valid      (out_byte_valid),
  .out_last_result     (out_last_result),
  .out_byte_count      (out_byte_count),
  .out_from_id         (out_from_id),
  .out_sent_count      (out_sent_count),
  .out_delivered_count (out_delivered_count),
  .out_refused_count   (out_refused_count)
);

// File: sim/tb_slot_mailbox_engine_unit.sv
// Self-checking testbench for the slot mailbox engine: directed and random beats.
module tb_slot_mailbox_engine_unit;
  import sme_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_BEATS = 100;
  localparam int TAIL_CYCLES  = 8;

  typedef struct packed {
    status_t           status;
    logic [7:0]        data;
    logic              data_valid;
    logic              last;
    logic [CNT_W-1:0]  count;
    logic [FROM_W-1:0] from;
    logic [31:0]       sent;
    logic [31:0]       delivered;
    logic [31:0]       refused;
  } mail_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_mode = '0;
  logic [7:0]               in_slot = '0;
  logic [7:0]               in_sender = '0;
  logic                     in_dest_running = 1'b0;
  logic [7:0]               in_length = '0;
  logic [7:0]               in_data_byte = '0;
  logic                     out_valid;
  logic [2:0]               out_status;
  logic [7:0]               out_out_byte;
  logic                     out_byte_valid;
  logic                     out_last_result;
  logic [CNT_W-1:0]         out_byte_count;
  logic signed [FROM_W-1:0] out_from_id;
  logic [31:0]              out_sent_count;
  logic [31:0]              out_delivered_count;
  logic [31:0]              out_refused_count;

  // mailbox state as the block should hold it
  logic [7:0]        mbox_bytes [MEM_DEPTH];
  logic [CNT_W-1:0]  mbox_len [NUM_SLOTS];
  logic [FROM_W-1:0] mbox_from [NUM_SLOTS];
  logic [31:0]       sent_total = '0;
  logic [31:0]       delivered_total = '0;
  logic [31:0]       refused_total = '0;
  logic              run_open = 1'b0;
  int                run_pos = 0;
  status_t           run_status = STS_OK;
  int                run_slot = 0;
  logic [7:0]        run_sender = '0;
  int                run_len = 0;

  mail_result_t expected_results[$];
  int           fail_count = 0;
  int           idle_cycles = 0;
  int           driven_beats = 0;
  int           model_beats = 0;
  bit           gapless = 1'b0;

  slot_mailbox_engine_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_slot             (in_slot),
    .in_sender           (in_sender),
    .in_dest_running     (in_dest_running),
    .in_length           (in_length),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_out_byte        (out_out_byte),
    .out_byte_valid      (out_byte_valid),
    .out_last_result     (out_last_result),
    .out_byte_count      (out_byte_count),
    .out_from_id         (out_from_id),
    .out_sent_count      (out_sent_count),
    .out_delivered_count (out_delivered_count),
    .out_refused_count   (out_refused_count)
  );

  always #6 clk = ~clk;

  // queue one result carrying the counters as they stand now
  function automatic void push_result(status_t status, logic [7:0] data, logic data_valid,
                                      logic last, int count, logic [FROM_W-1:0] from);
    mail_result_t r;
    r.status     = status;
    r.data       = data;
    r.data_valid = data_valid;
    r.last       = last;
    r.count      = CNT_W'(count);
    r.from       = from;
    r.sent       = sent_total;
    r.delivered  = delivered_total;
    r.refused    = refused_total;
    expected_results.push_back(r);
  endfunction

  // advance the mailbox state by one accepted beat and queue what it causes
  function automatic void predict_beat(logic [1:0] mode, logic [7:0] slot, logic [7:0] sender,
                                       logic running, logic [7:0] length, logic [7:0] data);
    int                take;
    int                items;
    logic [FROM_W-1:0] from;
    if (mode != MODE_SEND && mode != MODE_NONE) run_open = 1'b0;
    case (mode)
      MODE_SEND: begin
        // first beat of a run latches its fields and settles the verdict
        if (!run_open) begin
          run_open   = 1'b1;
          run_slot   = slot;
          run_sender = sender;
          run_len    = length;
          run_pos    = 0;
          if (slot >= NUM_SLOTS || length == 0 || length > MSG_MAX) run_status = STS_BAD_ARG;
          else if (!running) run_status = STS_NOT_RUN;
          else if (mbox_len[slot] != 0) run_status = STS_OCCUPIED;
          else run_status = STS_OK;
          if (run_status != STS_OK) refused_total++;
        end
        if (run_status == STS_OK && run_pos < MSG_MAX)
          mbox_bytes[run_slot * MSG_MAX + run_pos] = data;
        run_pos++;
        items = (run_len == 0) ? 1 : run_len;
        if (run_pos >= items) begin
          run_open = 1'b0;
          if (run_status == STS_OK) begin
            mbox_len[run_slot]  = CNT_W'(run_len);
            mbox_from[run_slot] = {1'b0, run_sender};
            sent_total++;
            push_result(STS_OK, '0, 1'b0, 1'b1, run_len, NO_SENDER);
          end else begin
            push_result(run_status, '0, 1'b0, 1'b1, 0, NO_SENDER);
          end
        end
      end
      MODE_RECV: begin
        if (slot >= NUM_SLOTS) begin
          push_result(STS_BAD_ARG, '0, 1'b0, 1'b1, 0, NO_SENDER);
        end else if (mbox_len[slot] == 0) begin
          push_result(STS_EMPTY, '0, 1'b0, 1'b1, 0, NO_SENDER);
        end else begin
          take = (mbox_len[slot] < length) ? mbox_len[slot] : length;
          from = mbox_from[slot];
          mbox_len[slot]  = '0;
          mbox_from[slot] = NO_SENDER;
          delivered_total++;
          if (take == 0) push_result(STS_OK, '0, 1'b0, 1'b1, 0, from);
          for (int i = 0; i < take; i++)
            push_result(STS_OK, mbox_bytes[slot * MSG_MAX + i], 1'b1, i == take - 1, take, from);
        end
      end
      MODE_CLEAR: begin
        if (slot < NUM_SLOTS) begin
          mbox_len[slot]  = '0;
          mbox_from[slot] = NO_SENDER;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
      fail_count++;
    end
  endfunction

  // check each result strobe, predict each accepted beat, watch for a hang
  always @(posedge clk) begin
    mail_result_t want;
    bit           progress;
    if (rst_n) begin
      progress = 1'b0;
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation pending");
          fail_count++;
        end else begin
          want     = expected_results.pop_front();
          progress = 1'b1;
          check_field("status", want.status, out_status);
          check_field("out_byte", want.data, out_out_byte);
          check_field("byte_valid", want.data_valid, out_byte_valid);
          check_field("last_result", want.last, out_last_result);
          check_field("byte_count", want.count, out_byte_count);
          check_field("from_id", want.from, $unsigned(out_from_id));
          check_field("sent_count", want.sent, out_sent_count);
          check_field("delivered_count", want.delivered, out_delivered_count);
          check_field("refused_count", want.refused, out_refused_count);
        end
      end
      if (start && !busy) begin
        predict_beat(in_mode, in_slot, in_sender, in_dest_running, in_length, in_data_byte);
        model_beats++;
        progress = 1'b1;
      end
      if (progress) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // mostly back to back, sometimes a short gap, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // hold start low with junk on the fields
  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk);
      start           <= 1'b0;
      in_mode         <= 2'($urandom);
      in_slot         <= 8'($urandom);
      in_sender       <= 8'($urandom);
      in_dest_running <= 1'($urandom);
      in_length       <= 8'($urandom);
      in_data_byte    <= 8'($urandom);
    end
  endtask

  // present one beat and hold it until the block takes it
  task automatic send_beat(logic [1:0] mode, logic [7:0] slot, logic [7:0] sender,
                           logic running, logic [7:0] length, logic [7:0] data);
    if (!gapless) pause_sender(pick_gap());
    @(negedge clk);
    start           <= 1'b1;
    in_mode         <= mode;
    in_slot         <= slot;
    in_sender       <= sender;
    in_dest_running <= running;
    in_length       <= length;
    in_data_byte    <= data;
    do @(posedge clk); while (busy);
    driven_beats++;
  endtask

  // later beats of a run carry junk in every field but the mode and the data byte
  task automatic send_run(logic [7:0] slot, logic [7:0] sender, logic running,
                          logic [7:0] length, int beats);
    for (int k = 0; k < beats; k++) begin
      if (k == 0) send_beat(MODE_SEND, slot, sender, running, length, 8'($urandom));
      else send_beat(MODE_SEND, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                     8'($urandom));
    end
  endtask

  function automatic int run_beats(logic [7:0] length);
    return (length == 0) ? 1 : length;
  endfunction

  task automatic take_mail(logic [7:0] slot, logic [7:0] max_bytes);
    send_beat(MODE_RECV, slot, 8'($urandom), 1'($urandom), max_bytes, 8'($urandom));
  endtask

  task automatic empty_slot(logic [7:0] slot);
    send_beat(MODE_CLEAR, slot, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic skip_beat();
    send_beat(MODE_NONE, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  // drop start and hold off until every expected result has come
  task automatic wait_results_drained();
    pause_sender(1);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // pick a slot, mostly one that is full (or empty) in the predicted state
  task automatic pick_slot(bit want_full, output logic [7:0] slot);
    int hits[$];
    wait (model_beats == driven_beats);
    for (int s = 0; s < NUM_SLOTS; s++)
      if ((mbox_len[s] != 0) == want_full) hits.push_back(s);
    if (hits.size() != 0 && $urandom_range(0, 9) < 8)
      slot = 8'(hits[$urandom_range(0, hits.size() - 1)]);
    else
      slot = 8'($urandom_range(0, NUM_SLOTS - 1));
  endtask

  // refusals, empty and out-of-range receives, zero takes, aborted runs
  task automatic test_directed_cases();
    take_mail(8'd0, 8'd8);
    take_mail(8'd255, 8'd1);
    take_mail(8'(NUM_SLOTS), 8'd1);
    send_run(8'd0, 8'd5, 1'b1, 8'd0, 1);
    send_run(8'(NUM_SLOTS), 8'd5, 1'b1, 8'd1, 1);
    send_run(8'd1, 8'd5, 1'b0, 8'd1, 1);
    send_run(8'd0, 8'd255, 1'b1, 8'd1, 1);
    send_run(8'd0, 8'd1, 1'b1, 8'd2, 2);
    take_mail(8'd0, 8'd255);
    send_run(8'd7, 8'd0, 1'b1, 8'd3, 3);
    take_mail(8'd7, 8'd0);
    take_mail(8'd7, 8'd3);
    // an ignored beat in the middle of a run leaves the run intact
    send_run(8'd2, 8'd77, 1'b1, 8'd2, 1);
    skip_beat();
    send_beat(MODE_SEND, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
              8'($urandom));
    empty_slot(8'd2);
    take_mail(8'd2, 8'd5);
    empty_slot(8'd255);
    // a receive or a clear abandons a run part way through
    send_run(8'd4, 8'd9, 1'b1, 8'd5, 2);
    take_mail(8'd4, 8'd5);
    send_run(8'd5, 8'd9, 1'b1, 8'(MSG_MAX + 1), 1);
    empty_slot(8'd5);
    send_run(8'd6, 8'd9, 1'b1, 8'd255, 1);
    take_mail(8'd6, 8'd1);
  endtask

  // largest message, taken whole
  task automatic test_full_length_messages();
    send_run(8'd3, 8'd128, 1'b1, 8'(MSG_MAX), MSG_MAX);
    take_mail(8'd3, 8'(MSG_MAX));
  endtask

  // a refused run still swallows every one of its beats
  task automatic test_long_refused_run();
    gapless = 1'b1;
    send_run(8'd3, 8'd3, 1'b1, 8'(MSG_MAX + 1), MSG_MAX + 1);
    gapless = 1'b0;
    take_mail(8'd0, 8'd1);
  endtask

  task automatic test_random_traffic();
    int         base;
    int         ignored;
    int         r;
    int         len_pick;
    int         part;
    bit         drained;
    logic [7:0] slot;
    logic [7:0] length;
    base    = driven_beats;
    ignored = 0;
    drained = 1'b0;
    while (driven_beats - base - ignored < RANDOM_BEATS) begin
      if ($urandom_range(0, 19) == 0) gapless = ~gapless;
      if (!drained && driven_beats - base > RANDOM_BEATS / 2) begin
        wait_results_drained();
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // well-formed send run with random content
        pick_slot(1'b0, slot);
        len_pick = $urandom_range(0, 99);
        if (len_pick < 3) length = 8'd0;
        else if (len_pick < 85) length = 8'($urandom_range(1, 12));
        else length = 8'($urandom_range(13, MSG_MAX));
        send_run(slot, 8'($urandom), $urandom_range(0, 9) != 0, length, run_beats(length));
      end else if (r < 80) begin
        if ($urandom_range(0, 9) < 8) pick_slot(1'b1, slot);
        else slot = 8'($urandom);
        len_pick = $urandom_range(0, 99);
        if (len_pick < 20) length = 8'($urandom_range(0, 3));
        else if (len_pick < 60) length = 8'($urandom);
        else length = 8'($urandom_range(MSG_MAX, 255));
        take_mail(slot, length);
      end else if (r < 88) begin
        if ($urandom_range(0, 1) == 0) empty_slot(8'($urandom_range(0, NUM_SLOTS + 1)));
        else empty_slot(8'($urandom));
      end else if (r < 93) begin
        skip_beat();
        ignored++;
      end else begin
        // broken run: cut short by a receive or a clear
        length = 8'($urandom);
        part   = (run_beats(length) > 1) ? $urandom_range(1, run_beats(length) - 1) : 1;
        if (part > 6) part = 6;
        if ($urandom_range(0, 1) == 0) slot = 8'($urandom);
        else slot = 8'($urandom_range(0, NUM_SLOTS - 1));
        send_run(slot, 8'($urandom), 1'($urandom), length, part);
        if ($urandom_range(0, 1) == 0) take_mail(slot, 8'($urandom));
        else empty_slot(slot);
      end
    end
    gapless = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < MEM_DEPTH; i++) mbox_bytes[i] = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      mbox_len[s]  = '0;
      mbox_from[s] = NO_SENDER;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_full_length_messages();
    test_long_refused_run();
    test_random_traffic();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
